// File: rtl/cec_pkg.sv
// ----------------------------------------------------------------------------
// Contour edge crossing package
// Widths, payload types and helpers shared by the crossing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cec_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int ALPHA_BITS = 24;
  localparam int DIFF_W     = DATA_WIDTH + 1;
  localparam int MAG_W      = DIFF_W;
  localparam int LO_W       = (MAG_W + 1) / 2;
  localparam int HI_W       = MAG_W - LO_W;
  localparam int PROD_W     = MAG_W + ALPHA_BITS;
  localparam int LP_W       = LO_W + ALPHA_BITS;
  localparam int HP_W       = HI_W + ALPHA_BITS;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] start_value;
    logic signed [DATA_WIDTH-1:0] end_value;
    logic signed [DATA_WIDTH-1:0] start_x;
    logic signed [DATA_WIDTH-1:0] start_y;
    logic signed [DATA_WIDTH-1:0] end_x;
    logic signed [DATA_WIDTH-1:0] end_y;
  } edge_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] crossing_x;
    logic signed [DATA_WIDTH-1:0] crossing_y;
  } crossing_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] start_x;
    logic signed [DATA_WIDTH-1:0] start_y;
    logic [MAG_W-1:0]             dx_mag;
    logic [MAG_W-1:0]             dy_mag;
    logic                         dx_neg;
    logic                         dy_neg;
  } side_t;

  typedef struct packed {
    logic [MAG_W-1:0]      rem;
    logic [MAG_W-1:0]      den;
    logic [ALPHA_BITS-1:0] alpha;
    side_t                 side;
  } div_t;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [DATA_WIDTH-1:0] v);
    sx = $signed({v[DATA_WIDTH-1], v});
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic signed [DIFF_W-1:0] n;
    n   = -v;
    mag = v[DIFF_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

endpackage

`default_nettype wire

// File: rtl/cec_front.sv
// ----------------------------------------------------------------------------
// Contour edge crossing front end
// Two stages: level differences, then crossing test and magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module cec_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 adv,
  input  wire logic                                 in_take,
  input  wire cec_pkg::edge_t                       in_data,
  input  wire logic [cec_pkg::DATA_WIDTH-1:0]       level,
  output logic                                      front_valid,
  output cec_pkg::div_t                             front_data
);

  typedef struct packed {
    logic signed [cec_pkg::DIFF_W-1:0]     da;
    logic signed [cec_pkg::DIFF_W-1:0]     db;
    logic signed [cec_pkg::DIFF_W-1:0]     dv;
    logic signed [cec_pkg::DIFF_W-1:0]     dx;
    logic signed [cec_pkg::DIFF_W-1:0]     dy;
    logic signed [cec_pkg::DATA_WIDTH-1:0] start_x;
    logic signed [cec_pkg::DATA_WIDTH-1:0] start_y;
  } diff_t;

  logic  a_valid;
  diff_t a_data;
  logic  a_cross;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_data.da      <= cec_pkg::sx(in_data.start_value) - cec_pkg::sx(level);
      a_data.db      <= cec_pkg::sx(in_data.end_value) - cec_pkg::sx(level);
      a_data.dv      <= cec_pkg::sx(in_data.start_value) - cec_pkg::sx(in_data.end_value);
      a_data.dx      <= cec_pkg::sx(in_data.end_x) - cec_pkg::sx(in_data.start_x);
      a_data.dy      <= cec_pkg::sx(in_data.end_y) - cec_pkg::sx(in_data.start_y);
      a_data.start_x <= in_data.start_x;
      a_data.start_y <= in_data.start_y;
    end
  end

  // Opposite strict signs; the denominator is then |start - end|.
  assign a_cross = (a_data.da != '0) && (a_data.db != '0) &&
                   (a_data.da[cec_pkg::DIFF_W-1] != a_data.db[cec_pkg::DIFF_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (adv) begin
      front_valid <= a_valid && a_cross;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      front_data.rem          <= cec_pkg::mag(a_data.da);
      front_data.den          <= cec_pkg::mag(a_data.dv);
      front_data.alpha        <= '0;
      front_data.side.start_x <= a_data.start_x;
      front_data.side.start_y <= a_data.start_y;
      front_data.side.dx_mag  <= cec_pkg::mag(a_data.dx);
      front_data.side.dy_mag  <= cec_pkg::mag(a_data.dy);
      front_data.side.dx_neg  <= a_data.dx[cec_pkg::DIFF_W-1];
      front_data.side.dy_neg  <= a_data.dy[cec_pkg::DIFF_W-1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/cec_divider.sv
// ----------------------------------------------------------------------------
// Contour edge crossing divider
// Pipelined restoring division, one fraction bit of alpha per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cec_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          div_in_valid,
  input  wire cec_pkg::div_t div_in,
  output logic               div_valid,
  output cec_pkg::div_t      div_data
);

  logic          vld [cec_pkg::ALPHA_BITS];
  cec_pkg::div_t st  [cec_pkg::ALPHA_BITS];

  for (genvar k = 0; k < cec_pkg::ALPHA_BITS; k++) begin : g_step
    logic                        src_valid;
    cec_pkg::div_t               src;
    logic [cec_pkg::MAG_W:0]     shifted;
    logic [cec_pkg::MAG_W:0]     diff;
    logic                        ge;

    if (k == 0) begin : g_first
      assign src_valid = div_in_valid;
      assign src       = div_in;
    end else begin : g_next
      assign src_valid = vld[k-1];
      assign src       = st[k-1];
    end

    assign shifted = {src.rem, 1'b0};
    assign diff    = shifted - {1'b0, src.den};
    assign ge      = shifted >= {1'b0, src.den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[k].rem   <= ge ? diff[cec_pkg::MAG_W-1:0] : shifted[cec_pkg::MAG_W-1:0];
        st[k].den   <= src.den;
        st[k].alpha <= {src.alpha[cec_pkg::ALPHA_BITS-2:0], ge};
        st[k].side  <= src.side;
      end
    end
  end

  assign div_valid = vld[cec_pkg::ALPHA_BITS-1];
  assign div_data  = st[cec_pkg::ALPHA_BITS-1];

endmodule

`default_nettype wire

// File: rtl/cec_interp.sv
// ----------------------------------------------------------------------------
// Contour edge crossing interpolator
// Partial products, product sum, then the signed offset from the start point.
// ----------------------------------------------------------------------------
`default_nettype none

module cec_interp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          div_valid,
  input  wire cec_pkg::div_t div_data,
  output logic               out_valid,
  output cec_pkg::crossing_t out_data
);

  logic                               p_valid;
  logic [cec_pkg::LP_W-1:0]           px_lo, py_lo;
  logic [cec_pkg::HP_W-1:0]           px_hi, py_hi;
  logic signed [cec_pkg::DATA_WIDTH-1:0] p_sx, p_sy, s_sx, s_sy;
  logic                               p_xneg, p_yneg, s_xneg, s_yneg;

  logic                               s_valid;
  logic [cec_pkg::PROD_W-1:0]         sum_x, sum_y;
  logic [cec_pkg::DATA_WIDTH-1:0]     off_x, off_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p_valid   <= div_valid;
      s_valid   <= p_valid;
      out_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_lo  <= cec_pkg::LP_W'(div_data.side.dx_mag[cec_pkg::LO_W-1:0]) *
                cec_pkg::LP_W'(div_data.alpha);
      py_lo  <= cec_pkg::LP_W'(div_data.side.dy_mag[cec_pkg::LO_W-1:0]) *
                cec_pkg::LP_W'(div_data.alpha);
      px_hi  <= cec_pkg::HP_W'(div_data.side.dx_mag[cec_pkg::MAG_W-1:cec_pkg::LO_W]) *
                cec_pkg::HP_W'(div_data.alpha);
      py_hi  <= cec_pkg::HP_W'(div_data.side.dy_mag[cec_pkg::MAG_W-1:cec_pkg::LO_W]) *
                cec_pkg::HP_W'(div_data.alpha);
      p_sx   <= div_data.side.start_x;
      p_sy   <= div_data.side.start_y;
      p_xneg <= div_data.side.dx_neg;
      p_yneg <= div_data.side.dy_neg;

      sum_x  <= (cec_pkg::PROD_W'(px_hi) << cec_pkg::LO_W) + cec_pkg::PROD_W'(px_lo);
      sum_y  <= (cec_pkg::PROD_W'(py_hi) << cec_pkg::LO_W) + cec_pkg::PROD_W'(py_lo);
      s_sx   <= p_sx;
      s_sy   <= p_sy;
      s_xneg <= p_xneg;
      s_yneg <= p_yneg;

      out_data.crossing_x <= s_xneg ? s_sx - $signed(off_x) : s_sx + $signed(off_x);
      out_data.crossing_y <= s_yneg ? s_sy - $signed(off_y) : s_sy + $signed(off_y);
    end
  end

  // The point lies between the endpoints, so the low word of the offset suffices.
  assign off_x = sum_x[cec_pkg::ALPHA_BITS +: cec_pkg::DATA_WIDTH];
  assign off_y = sum_y[cec_pkg::ALPHA_BITS +: cec_pkg::DATA_WIDTH];

endmodule

`default_nettype wire

// File: rtl/contour_edge_crossing_core.sv
// ----------------------------------------------------------------------------
// Contour edge crossing core
// Finds where a contour level crosses a mesh edge by linear interpolation.
// ----------------------------------------------------------------------------
// Channel   Signals                          Payload
// in        in_valid / in_ready              cec_pkg::edge_t      (one edge)
// out       out_valid / out_ready            cec_pkg::crossing_t  (crossing point)
// cfg       cfg_valid / cfg_ready            contour level, signed Q16.16
//
// One edge request is taken every cycle unless the output stalls; a crossing
// passes two front stages, one stage per alpha bit in the divider, three in
// the interpolator. Edges without a strict crossing leave no result.
// Reset empties the pipeline and sets the contour level to zero.
// While a result waits on out_ready the whole pipeline holds and in_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module contour_edge_crossing_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire cec_pkg::edge_t                 in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output cec_pkg::crossing_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cec_pkg::DATA_WIDTH-1:0] cfg_data
);

  logic [cec_pkg::DATA_WIDTH-1:0] level;
  logic                           adv;
  logic                           front_valid;
  cec_pkg::div_t                  front_data;
  logic                           div_valid;
  cec_pkg::div_t                  div_data;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      level <= cfg_data;
    end
  end

  cec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_take     (in_valid && in_ready),
    .in_data     (in_data),
    .level       (level),
    .front_valid (front_valid),
    .front_data  (front_data)
  );

  cec_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .div_in_valid (front_valid),
    .div_in       (front_data),
    .div_valid    (div_valid),
    .div_data     (div_data)
  );

  cec_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .div_valid (div_valid),
    .div_data  (div_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid && !front_valid)
    else $error("pipeline not empty after reset");

  a_level_hit_drops: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.start_value == level) ##1 in_ready |=> !front_valid)
    else $error("edge touching the level entered the divider");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(div_valid) && $stable(div_data))
    else $error("divider moved while the output was stalled");

endmodule

`default_nettype wire
